// ===== rtl/core/bsch_pkg.sv =====
// Shared types and codes of the burst scheduler.
`timescale 1ns / 1ps

package bsch_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_BURST = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic REG_POLICY     = 1'b0;
  localparam logic REG_TIME_SLICE = 1'b1;

  localparam logic POLICY_RR    = 1'b1;
  localparam logic KIND_RES     = 1'b1;
  localparam logic [7:0] SLICE_RESET = 8'd2;
  localparam logic [7:0] SLICE_SAT   = 8'd255;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] process_id;
    logic [3:0] slot;
    logic [9:0] arrival_tick;
    logic       burst_kind;
    logic [7:0] burst_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cpu_owner;
    logic [7:0] resource_owner;
    logic [9:0] tick_number;
    logic       all_finished;
    logic       time_overflow;
  } out_item_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_ROUTE_RD,
    S_ROUTE_WR,
    S_RES,
    S_RES_ID,
    S_RES_RUN,
    S_CPU,
    S_CPU_POP,
    S_CPU_ID,
    S_CPU_RUN,
    S_FIN
  } sched_state_t;

endpackage

// ===== rtl/core/bsch_ram.sv =====
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps

module bsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bsch_fifo.sv =====
// Circular queue of process slots with head and count pointers.
`timescale 1ns / 1ps

module bsch_fifo import bsch_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int W     = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head_data,
  output fifo_stat_t   stat
);

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] head;
  logic [CW-1:0] count;
  logic [CW:0]   tail_sum;
  logic [PW-1:0] tail;
  logic          do_push;
  logic          do_pop;

  assign tail_sum = (CW + 1)'(head) + (CW + 1)'(count);
  assign tail = (tail_sum >= (CW + 1)'(DEPTH)) ? PW'(tail_sum - (CW + 1)'(DEPTH))
                                               : PW'(tail_sum);

  assign stat.full     = (count == CW'(DEPTH));
  assign stat.nonempty = (count != '0);
  assign head_data     = mem[head];

  // A push into a full queue is dropped, as is a pop from an empty one.
  assign do_push = push && !stat.full;
  assign do_pop  = pop && stat.nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (do_pop) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/cpu_and_device_burst_scheduler_core.sv =====
// Top level of the tick-driven CPU and shared-resource burst scheduler.
// Usage: items enter on in_valid/in_ready as in_data. An add-process item loads the next
// table slot, an append-burst item adds a CPU or resource burst to a loaded slot; neither
// gives a result. An advance-tick item gives exactly one result on out_valid/out_ready as
// out_data: the owners of CPU and resource for that tick, the tick number and the done and
// overflow flags. policy and time_slice are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce this.
// The arrival scan through the arrival table's single read port and the burst table
// lookups set the length of a tick; a tick on which nothing is scheduled goes straight
// to its result. in_ready is low for the whole tick.
// The result sits in an output register; a stalled receiver holds it there and the block
// keeps taking add and append items, but a following tick waits at its end until the
// register is free. Synchronous reset empties both queues, clears all counts, holders
// and flags, and sets policy to first come first served with a quantum of two.
`timescale 1ns / 1ps

module cpu_and_device_burst_scheduler_core import bsch_pkg::*; #(
  parameter int PROC_SLOTS      = 16,
  parameter int BURSTS_PER_PROC = 8,
  parameter int MAX_TICKS       = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_write,
  input  logic      cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int SLOT_W   = PROC_SLOTS > 1 ? $clog2(PROC_SLOTS) : 1;
  localparam int CNT_W    = $clog2(PROC_SLOTS + 1);
  localparam int BC_W     = $clog2(BURSTS_PER_PROC + 1);
  localparam int BT_DEPTH = PROC_SLOTS * BURSTS_PER_PROC;
  localparam int BT_AW    = BT_DEPTH > 1 ? $clog2(BT_DEPTH) : 1;
  localparam int TICK_W   = $clog2(MAX_TICKS + 1);
  localparam int SCMP_W   = CNT_W > 4 ? CNT_W : 4;
  localparam int ACMP_W   = TICK_W > 10 ? TICK_W : 10;

  sched_state_t state, state_next, ret_state;

  logic [BC_W-1:0]   burst_counts [PROC_SLOTS];
  logic [BC_W-1:0]   burst_cursor [PROC_SLOTS];
  logic [7:0]        ticks_left   [PROC_SLOTS];

  logic [SLOT_W-1:0] cpu_holder, resource_holder, route_slot, sel;
  logic              cpu_valid, resource_valid;
  logic [7:0]        slice_used;
  logic [TICK_W-1:0] current_tick;
  logic [CNT_W-1:0]  loaded_count, finished_count, scan_idx;
  logic              overflow_flag, active, policy;
  logic [7:0]        time_slice;
  logic [7:0]        cpu_id, res_id;
  logic [9:0]        tick_out;

  logic              accept, table_full, burst_ok, pre_ovf, fin_go, ovf_set, unfinished;
  logic [BC_W-1:0]   cnt_sel, cur_sel;
  logic [7:0]        tl_sel, tl_dec, route_len;
  logic              ended, more, arrival_match, slice_out;
  logic [TICK_W-1:0] tick_inc;

  logic [7:0]        proc_rdata;
  logic [9:0]        arr_rdata;
  logic [8:0]        bt_rdata, bt_wdata;
  logic [SLOT_W-1:0] proc_raddr;
  logic [BT_AW-1:0]  bt_waddr, bt_raddr;
  logic              tbl_we, bt_we;

  logic              rq_push, rq_pop, sq_push, sq_pop;
  logic [SLOT_W-1:0] rq_push_data, rq_head, sq_head;
  fifo_stat_t        rq_stat, sq_stat;

  // Shared slot index for the per-process registers: one slot is touched per cycle.
  always_comb begin
    unique case (state)
      S_IDLE:                 sel = (in_data.operation == OP_ADD) ? SLOT_W'(loaded_count)
                                                                  : SLOT_W'(in_data.slot);
      S_SCAN_CMP:             sel = SLOT_W'(scan_idx);
      S_RES_RUN:              sel = resource_holder;
      S_CPU_RUN:              sel = cpu_holder;
      default:                sel = route_slot;
    endcase
  end

  assign cnt_sel = burst_counts[sel];
  assign cur_sel = burst_cursor[sel];
  assign tl_sel  = ticks_left[sel];
  assign tl_dec  = (tl_sel == '0) ? '0 : tl_sel - 1'b1;
  assign ended   = (tl_dec == '0);
  assign more    = ((BC_W + 1)'(cur_sel) + 1'b1) < (BC_W + 1)'(cnt_sel);

  assign accept     = in_valid && in_ready;
  assign table_full = (loaded_count == CNT_W'(PROC_SLOTS));
  assign burst_ok   = (SCMP_W'(in_data.slot) < SCMP_W'(loaded_count)) &&
                      (cnt_sel < BC_W'(BURSTS_PER_PROC));
  assign unfinished = (finished_count < loaded_count);
  assign pre_ovf    = overflow_flag || (unfinished && current_tick >= TICK_W'(MAX_TICKS));
  assign arrival_match = (ACMP_W'(arr_rdata) == ACMP_W'(current_tick));
  assign slice_out  = (slice_used >= time_slice);
  assign route_len  = (bt_rdata[7:0] == '0) ? 8'd1 : bt_rdata[7:0];
  assign fin_go     = !out_valid || out_ready;
  assign tick_inc   = current_tick + 1'b1;
  assign ovf_set    = active && unfinished && (tick_inc >= TICK_W'(MAX_TICKS));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && in_data.operation == OP_TICK) begin
          state_next = (!pre_ovf && unfinished) ? S_SCAN_RD : S_FIN;
        end
      end
      S_SCAN_RD:  state_next = (scan_idx == loaded_count) ? S_RES : S_SCAN_CMP;
      S_SCAN_CMP: state_next = (arrival_match && cnt_sel != '0) ? S_ROUTE_RD : S_SCAN_RD;
      S_ROUTE_RD: state_next = S_ROUTE_WR;
      S_ROUTE_WR: state_next = ret_state;
      S_RES:      state_next = S_RES_ID;
      S_RES_ID:   state_next = S_RES_RUN;
      S_RES_RUN:  state_next = (resource_valid && ended && more) ? S_ROUTE_RD : S_CPU;
      S_CPU:      state_next = S_CPU_POP;
      S_CPU_POP:  state_next = S_CPU_ID;
      S_CPU_ID:   state_next = S_CPU_RUN;
      S_CPU_RUN:  state_next = (cpu_valid && ended && more) ? S_ROUTE_RD : S_FIN;
      S_FIN:      state_next = fin_go ? S_IDLE : S_FIN;
      default:    state_next = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready     = 1'b0;
    tbl_we       = 1'b0;
    bt_we        = 1'b0;
    rq_push      = 1'b0;
    rq_pop       = 1'b0;
    sq_push      = 1'b0;
    sq_pop       = 1'b0;
    rq_push_data = route_slot;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        tbl_we   = accept && in_data.operation == OP_ADD && !table_full;
        bt_we    = accept && in_data.operation == OP_BURST && burst_ok;
      end
      S_ROUTE_WR: begin
        rq_push = (bt_rdata[8] != KIND_RES);
        sq_push = (bt_rdata[8] == KIND_RES);
      end
      S_RES: sq_pop = !resource_valid;
      S_CPU: begin
        // A preempted holder goes to the tail before the next pick.
        rq_push      = (policy == POLICY_RR) && cpu_valid && slice_out;
        rq_push_data = cpu_holder;
      end
      S_CPU_POP: rq_pop = (policy == POLICY_RR) ? (!cpu_valid || slice_out) : !cpu_valid;
      default: begin
      end
    endcase
  end

  assign proc_raddr = (state == S_RES_ID) ? resource_holder : cpu_holder;
  assign bt_wdata   = {in_data.burst_kind,
                       (in_data.burst_length == '0) ? 8'd1 : in_data.burst_length};
  assign bt_waddr   = BT_AW'(int'(sel) * BURSTS_PER_PROC) + BT_AW'(cnt_sel);
  assign bt_raddr   = BT_AW'(int'(sel) * BURSTS_PER_PROC) + BT_AW'(cur_sel);

  bsch_ram #(.WIDTH(8), .DEPTH(PROC_SLOTS)) u_proc_ids (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (SLOT_W'(loaded_count)),
    .wdata (in_data.process_id),
    .raddr (proc_raddr),
    .rdata (proc_rdata)
  );

  bsch_ram #(.WIDTH(10), .DEPTH(PROC_SLOTS)) u_arrivals (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (SLOT_W'(loaded_count)),
    .wdata (in_data.arrival_tick),
    .raddr (SLOT_W'(scan_idx)),
    .rdata (arr_rdata)
  );

  bsch_ram #(.WIDTH(9), .DEPTH(BT_DEPTH)) u_bursts (
    .clk   (clk),
    .we    (bt_we),
    .waddr (bt_waddr),
    .wdata (bt_wdata),
    .raddr (bt_raddr),
    .rdata (bt_rdata)
  );

  bsch_fifo #(.DEPTH(PROC_SLOTS), .W(SLOT_W)) u_ready_q (
    .clk       (clk),
    .rst       (rst),
    .push      (rq_push),
    .push_data (rq_push_data),
    .pop       (rq_pop),
    .head_data (rq_head),
    .stat      (rq_stat)
  );

  bsch_fifo #(.DEPTH(PROC_SLOTS), .W(SLOT_W)) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (sq_push),
    .push_data (route_slot),
    .pop       (sq_pop),
    .head_data (sq_head),
    .stat      (sq_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ret_state      <= S_IDLE;
      cpu_valid      <= 1'b0;
      resource_valid <= 1'b0;
      slice_used     <= '0;
      current_tick   <= '0;
      loaded_count   <= '0;
      finished_count <= '0;
      overflow_flag  <= 1'b0;
      active         <= 1'b0;
      policy         <= 1'b0;
      time_slice     <= SLICE_RESET;
      out_valid      <= 1'b0;
      for (int i = 0; i < PROC_SLOTS; i++) begin
        burst_counts[i] <= '0;
        burst_cursor[i] <= '0;
        ticks_left[i]   <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_index)
          REG_POLICY:     policy     <= cfg_data[0];
          REG_TIME_SLICE: time_slice <= cfg_data;
          default:        policy     <= policy;
        endcase
      end

      if (state == S_FIN && fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_data.operation)
              OP_ADD: begin
                if (!table_full) begin
                  burst_counts[sel] <= '0;
                  burst_cursor[sel] <= '0;
                  ticks_left[sel]   <= '0;
                  loaded_count      <= loaded_count + 1'b1;
                end
              end
              OP_BURST: begin
                if (burst_ok) begin
                  burst_counts[sel] <= cnt_sel + 1'b1;
                end
              end
              OP_TICK: begin
                overflow_flag <= pre_ovf;
                active        <= !pre_ovf && unfinished;
                tick_out      <= 10'(current_tick);
                cpu_id        <= '0;
                res_id        <= '0;
                scan_idx      <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN_CMP: begin
          scan_idx <= scan_idx + 1'b1;
          if (arrival_match) begin
            burst_cursor[sel] <= '0;
            if (cnt_sel == '0) begin
              finished_count <= finished_count + 1'b1;
            end else begin
              route_slot <= sel;
              ret_state  <= S_SCAN_RD;
            end
          end
        end
        S_ROUTE_WR: ticks_left[sel] <= route_len;
        S_RES: begin
          if (!resource_valid && sq_stat.nonempty) begin
            resource_holder <= sq_head;
            resource_valid  <= 1'b1;
          end
        end
        S_RES_RUN: begin
          if (resource_valid) begin
            res_id          <= proc_rdata;
            ticks_left[sel] <= tl_dec;
            if (ended) begin
              resource_valid <= 1'b0;
              if (more) begin
                burst_cursor[sel] <= cur_sel + 1'b1;
                route_slot        <= sel;
                ret_state         <= S_CPU;
              end else begin
                finished_count <= finished_count + 1'b1;
              end
            end
          end
        end
        S_CPU_POP: begin
          if (policy == POLICY_RR) begin
            if (!cpu_valid || slice_out) begin
              cpu_valid  <= rq_stat.nonempty;
              slice_used <= '0;
              if (rq_stat.nonempty) begin
                cpu_holder <= rq_head;
              end
            end
          end else if (!cpu_valid && rq_stat.nonempty) begin
            cpu_holder <= rq_head;
            cpu_valid  <= 1'b1;
            slice_used <= '0;
          end
        end
        S_CPU_RUN: begin
          if (cpu_valid) begin
            cpu_id          <= proc_rdata;
            // The slice count restarts when the burst ends.
            slice_used      <= ended ? '0 :
                               (slice_used == SLICE_SAT) ? slice_used : slice_used + 1'b1;
            ticks_left[sel] <= tl_dec;
            if (ended) begin
              cpu_valid <= 1'b0;
              if (more) begin
                burst_cursor[sel] <= cur_sel + 1'b1;
                route_slot        <= sel;
                ret_state         <= S_FIN;
              end else begin
                finished_count <= finished_count + 1'b1;
              end
            end
          end
        end
        S_FIN: begin
          if (fin_go) begin
            if (active) begin
              current_tick <= tick_inc;
            end
            if (ovf_set) begin
              overflow_flag <= 1'b1;
            end
            out_data.cpu_owner      <= cpu_id;
            out_data.resource_owner <= res_id;
            out_data.tick_number    <= tick_out;
            out_data.all_finished   <= !unfinished;
            out_data.time_overflow  <= overflow_flag || ovf_set;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/bsch_checker.sv =====
// Port-level checks of the burst scheduler and their bind to the top level.
`timescale 1ns / 1ps

module bsch_checker import bsch_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A result waiting on a stalled receiver holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A tick item keeps the block busy for at least the next cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.operation == OP_TICK |=> !in_ready)
    else $error("tick item did not occupy the sequencer");

  // Overflow is only raised while some process is unfinished.
  a_ovf_unfinished: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.time_overflow |-> !out_data.all_finished)
    else $error("overflow reported together with all finished");

endmodule

bind cpu_and_device_burst_scheduler_core bsch_checker u_bsch_checker (.*);

// ===== tb/sv/cpu_and_device_burst_scheduler_core_test.sv =====
// Self-checking testbench for the CPU and shared-resource burst scheduler.
`timescale 1ns / 1ps

module cpu_and_device_burst_scheduler_core_test;
  import bsch_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int SLOTS = 16;
  localparam int BURSTS = 8;
  localparam int TICK_LIMIT = 1024;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 1000000;

  class sched_board;
    logic [7:0] ids[SLOTS];
    logic [9:0] arrivals[SLOTS];
    logic [8:0] bursts[SLOTS][BURSTS];
    int burst_cnt[SLOTS];
    int cursor[SLOTS];
    int left[SLOTS];
    int ready_q[$];
    int device_q[$];
    int cpu_slot, dev_slot, slice_used, cur_tick, loaded, finished;
    bit cpu_busy, dev_busy, overflow, round_robin;
    int quantum;
    out_item_t expected_ticks[$];
    int errors;

    function new();
      cpu_busy = 0; dev_busy = 0; overflow = 0; round_robin = 0;
      quantum = SLICE_RESET; slice_used = 0; cur_tick = 0;
      loaded = 0; finished = 0; errors = 0;
      foreach (burst_cnt[i]) begin
        burst_cnt[i] = 0; cursor[i] = 0; left[i] = 0;
      end
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == REG_POLICY) round_robin = (val[0] == POLICY_RR);
      else quantum = val;
    endfunction

    function bit all_done();
      return overflow || finished >= loaded;
    endfunction

    function void enqueue(int s);
      logic [8:0] e;
      e = bursts[s][cursor[s] % BURSTS];
      left[s] = (e[7:0] == 0) ? 1 : e[7:0];
      if (e[8] == KIND_RES) begin
        if (device_q.size() < SLOTS) device_q.push_back(s);
      end else if (ready_q.size() < SLOTS) ready_q.push_back(s);
    endfunction

    function void burst_over(int s);
      if (cursor[s] + 1 < burst_cnt[s]) begin
        cursor[s]++;
        enqueue(s);
      end else finished++;
    endfunction

    function bit run_tick(int s);
      if (left[s] > 0) left[s]--;
      return left[s] == 0;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      int tick_seen;
      int len;
      r = '0;
      case (it.operation)
        OP_ADD: begin
          if (loaded < SLOTS) begin
            ids[loaded] = it.process_id;
            arrivals[loaded] = it.arrival_tick;
            burst_cnt[loaded] = 0; cursor[loaded] = 0; left[loaded] = 0;
            loaded++;
          end
        end
        OP_BURST: begin
          if (it.slot < loaded && burst_cnt[it.slot] < BURSTS) begin
            len = (it.burst_length == 0) ? 1 : it.burst_length;
            bursts[it.slot][burst_cnt[it.slot]] = {it.burst_kind, len[7:0]};
            burst_cnt[it.slot]++;
          end
        end
        OP_TICK: begin
          if (!overflow && finished < loaded && cur_tick >= TICK_LIMIT) overflow = 1;
          tick_seen = cur_tick;
          if (!overflow && finished < loaded) begin
            for (int i = 0; i < loaded; i++) begin
              if (arrivals[i] == cur_tick) begin
                cursor[i] = 0;
                if (burst_cnt[i] == 0) finished++;
                else enqueue(i);
              end
            end
            if (!dev_busy && device_q.size() > 0) begin
              dev_slot = device_q.pop_front();
              dev_busy = 1;
            end
            if (dev_busy) begin
              r.resource_owner = ids[dev_slot];
              if (run_tick(dev_slot)) begin
                dev_busy = 0;
                burst_over(dev_slot);
              end
            end
            if (round_robin) begin
              if (!cpu_busy || slice_used >= quantum) begin
                if (cpu_busy && ready_q.size() < SLOTS) ready_q.push_back(cpu_slot);
                cpu_busy = ready_q.size() > 0;
                if (cpu_busy) cpu_slot = ready_q.pop_front();
                slice_used = 0;
              end
            end else if (!cpu_busy && ready_q.size() > 0) begin
              cpu_slot = ready_q.pop_front();
              cpu_busy = 1;
              slice_used = 0;
            end
            if (cpu_busy) begin
              r.cpu_owner = ids[cpu_slot];
              if (slice_used < SLICE_SAT) slice_used++;
              if (run_tick(cpu_slot)) begin
                cpu_busy = 0;
                slice_used = 0;
                burst_over(cpu_slot);
              end
            end
            cur_tick++;
            if (finished < loaded && cur_tick >= TICK_LIMIT) overflow = 1;
          end
          r.tick_number = tick_seen[9:0];
          r.all_finished = finished >= loaded;
          r.time_overflow = overflow;
          expected_ticks.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_ticks.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_ticks.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"tick %0d: expected cpu %0d res %0d tick %0d done %0d ovf %0d, ",
                    "got cpu %0d res %0d tick %0d done %0d ovf %0d"},
                   want.tick_number, want.cpu_owner, want.resource_owner, want.tick_number,
                   want.all_finished, want.time_overflow, got.cpu_owner, got.resource_owner,
                   got.tick_number, got.all_finished, got.time_overflow);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  logic cfg_write = 0;
  logic cfg_index = 0;
  logic [7:0] cfg_data = '0;

  sched_board board = new();
  bit calm = 0;
  bit hold_req = 0;
  int cycles = 0;

  cpu_and_device_burst_scheduler_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cpu_and_device_burst_scheduler_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
  end

  // The receiver stalls at random; a requested hold-off keeps it stalled for a long stretch.
  always @(negedge clk) begin
    if (hold_req) begin
      out_ready = 0;
      repeat (400) @(negedge clk);
      hold_req = 0;
    end
    out_ready = calm ? 1'b1 : ($urandom_range(99) >= 28);
  end

  task automatic send(in_item_t it);
    while (!calm && $urandom_range(99) < 28) begin
      @(negedge clk);
      in_valid = 0;
    end
    @(negedge clk);
    in_valid = 1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    board.note_input(it);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic add_proc(logic [7:0] id, logic [9:0] arr);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    it.operation = OP_ADD;
    it.process_id = id;
    it.arrival_tick = arr;
    send(it);
  endtask

  task automatic add_burst(logic [3:0] slot, logic kind, logic [7:0] len);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    it.operation = OP_BURST;
    it.slot = slot;
    it.burst_kind = kind;
    it.burst_length = len;
    send(it);
  endtask

  task automatic do_op(logic [1:0] op);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
    it.operation = op;
    send(it);
  endtask

  // Registers change only once every tick result is back and the block has settled.
  task automatic settle_and_write(logic idx, logic [7:0] val);
    while (board.expected_ticks.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_write = 0;
  endtask

  function automatic logic [7:0] pick_len();
    if ($urandom_range(29) == 0) return $urandom_range(255);
    return $urandom_range(1, 4);
  endfunction

  task automatic run_to_done();
    while (!board.all_done()) begin
      case ($urandom_range(19))
        0: add_burst($urandom_range(15), $urandom_range(1), pick_len());
        1: do_op(OP_NONE);
        default: do_op(OP_TICK);
      endcase
    end
  endtask

  task automatic load_phase(int nproc);
    int base;
    base = board.loaded;
    for (int k = 0; k < nproc; k++)
      add_proc($urandom_range(1, 255), board.cur_tick + $urandom_range(3));
    for (int k = 0; k < nproc; k++) begin
      int nb;
      nb = $urandom_range(6);
      for (int b = 0; b < nb; b++) add_burst(base + k, $urandom_range(1), pick_len());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Idle tick with nothing loaded, an unknown operation and an append to an empty slot.
    do_op(OP_TICK);
    do_op(OP_NONE);
    add_burst(4'd15, 1'b0, 8'd3);

    // Zero id with same-kind bursts, zero length and a full burst list; a process
    // with no bursts.
    add_proc(8'd0, 10'd0);
    add_proc(8'd255, 10'd1);
    add_burst(0, 0, 8'd0);
    add_burst(0, 0, 8'd1);
    add_burst(0, KIND_RES, 8'd2);
    add_burst(0, KIND_RES, 8'd1);
    add_burst(0, 0, 8'd255);
    for (int b = 0; b < 4; b++) add_burst(0, $urandom_range(1), $urandom_range(1, 3));
    while (board.cur_tick < 4) do_op(OP_TICK);
    // A late append to process 0, whose burst list is already full.
    add_burst(0, 0, 8'd2);
    run_to_done();

    settle_and_write(REG_POLICY, POLICY_RR);
    settle_and_write(REG_TIME_SLICE, 8'd1);
    load_phase(3);
    run_to_done();

    settle_and_write(REG_TIME_SLICE, 8'd0);
    hold_req = 1;
    load_phase(3);
    run_to_done();

    settle_and_write(REG_TIME_SLICE, 8'd255);
    calm = 1;
    load_phase(3);
    run_to_done();
    calm = 0;

    settle_and_write(REG_TIME_SLICE, 8'd3);
    load_phase(3);
    // Switch policy between runs to cover first come first served at the end too.
    run_to_done();
    settle_and_write(REG_POLICY, 1'b0);
    load_phase(1);
    run_to_done();

    // A process loaded after its arrival tick never runs, so time runs out.
    add_proc($urandom_range(1, 255), 10'd0);
    add_proc($urandom_range(1, 255), 10'd1023);
    add_burst(15, 0, 8'd5);
    add_proc(8'd77, 10'd1000);
    while (!board.overflow) begin
      if ($urandom_range(9) == 0) add_burst($urandom_range(15), $urandom_range(1), pick_len());
      else do_op(OP_TICK);
    end
    repeat (3) do_op(OP_TICK);

    while (board.expected_ticks.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("cpu_and_device_burst_scheduler_core: match");
    else
      $display("cpu_and_device_burst_scheduler_core: mismatch");
    $finish;
  end

endmodule
